// ===== rtl/unsigned_to_decimal_ascii_top_macros.svh =====
// Assertion macros shared by the decimal ASCII converter modules
`ifndef UNSIGNED_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define UNSIGNED_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Property checked at every clock edge outside reset
`define UDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define UDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/u2da_pkg.sv =====
// Shared types and constants for the decimal ASCII converter
package u2da_pkg;

    localparam logic [5:0] ASCII_ZERO = 6'd48;
    localparam int FREE_WIDTH = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_CHECK,
        ST_EMIT,
        ST_ERROR
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic step;
        logic emit_digit;
        logic emit_error;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bits_done;
        logic fits;
        logic last_digit;
        logic out_free;
    } status_t;

endpackage

// ===== rtl/u2da_ctrl.sv =====
// Controller state machine for the decimal ASCII converter
`include "unsigned_to_decimal_ascii_top_macros.svh"

module u2da_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output u2da_pkg::cmd_t     cmd,
    input  u2da_pkg::status_t  sts
);

    u2da_pkg::state_t state_reg;
    u2da_pkg::state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= u2da_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            u2da_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = u2da_pkg::ST_CONVERT;
                end
            end
            u2da_pkg::ST_CONVERT: begin
                cmd.step = 1'b1;
                if (sts.bits_done) begin
                    state_next = u2da_pkg::ST_CHECK;
                end
            end
            u2da_pkg::ST_CHECK: begin
                state_next = sts.fits ? u2da_pkg::ST_EMIT : u2da_pkg::ST_ERROR;
            end
            u2da_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit_digit = 1'b1;
                    if (sts.last_digit) begin
                        state_next = u2da_pkg::ST_IDLE;
                    end
                end
            end
            u2da_pkg::ST_ERROR: begin
                if (sts.out_free) begin
                    cmd.emit_error = 1'b1;
                    state_next     = u2da_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = u2da_pkg::ST_IDLE;
            end
        endcase
    end

    `UDA_ASSERT(a_cmd_onehot, $onehot0({cmd.load, cmd.step, cmd.emit_digit, cmd.emit_error}), "more than one command")
    `UDA_ASSERT(a_emit_fits, (state_reg == u2da_pkg::ST_EMIT) |-> sts.fits, "emitting digits that do not fit")
    `UDA_ASSERT(a_error_nofit, (state_reg == u2da_pkg::ST_ERROR) |-> !sts.fits, "error status although digits fit")

endmodule

// ===== rtl/u2da_datapath.sv =====
// Double-dabble converter, digit store and output register
`include "unsigned_to_decimal_ascii_top_macros.svh"

module u2da_datapath #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [VALUE_WIDTH-1:0]              in_value,
    input  logic [u2da_pkg::FREE_WIDTH-1:0]     in_free,
    input  u2da_pkg::cmd_t                      cmd,
    output u2da_pkg::status_t                   sts,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [7:0]                          m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                                m_tlast,
    output logic                                m_tuser    // [0] status
);

    // Decimal digits of the largest value, plus one spare top digit
    localparam int NUM_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int DCW        = $clog2(NUM_DIGITS + 1);
    localparam int BCW        = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0]          value_reg;
    logic [u2da_pkg::FREE_WIDTH-1:0] free_reg;
    logic [3:0]                      bcd_reg  [0:NUM_DIGITS];
    logic [3:0]                      bcd_next [0:NUM_DIGITS];
    logic [3:0]                      adj      [0:NUM_DIGITS];
    logic [DCW-1:0]                  ndig_reg;
    logic [DCW-1:0]                  ptr_reg;
    logic [BCW-1:0]                  bit_cnt_reg;
    logic                            grow;
    logic [5:0]                      digit_reg;
    logic                            last_reg;
    logic                            status_reg;
    logic                            valid_reg;

    // One double-dabble step: add 3 to digits of five or more, then shift in the next bit
    always_comb begin
        for (int i = 0; i <= NUM_DIGITS; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? bcd_reg[i] + 4'd3 : bcd_reg[i];
        end
        bcd_next[0] = {adj[0][2:0], value_reg[VALUE_WIDTH-1]};
        for (int i = 1; i <= NUM_DIGITS; i++) begin
            bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    // Digit count grows by at most one per step
    always_comb begin
        grow = 1'b0;
        for (int i = 0; i <= NUM_DIGITS; i++) begin
            if ((DCW'(i) >= ndig_reg) && (bcd_next[i] != 4'd0)) begin
                grow = 1'b1;
            end
        end
    end

    // Conversion registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ndig_reg <= DCW'(1);
        end else if (cmd.load) begin
            value_reg   <= in_value;
            free_reg    <= in_free;
            ndig_reg    <= DCW'(1);
            ptr_reg     <= '0;
            bit_cnt_reg <= BCW'(VALUE_WIDTH - 1);
            for (int i = 0; i <= NUM_DIGITS; i++) begin
                bcd_reg[i] <= 4'd0;
            end
        end else if (cmd.step) begin
            value_reg   <= value_reg << 1;
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
            bcd_reg     <= bcd_next;
            if (grow) begin
                ndig_reg <= ndig_reg + 1'b1;
                ptr_reg  <= ndig_reg;
            end else begin
                ptr_reg  <= ndig_reg - 1'b1;
            end
        end else if (cmd.emit_digit) begin
            ptr_reg <= ptr_reg - 1'b1;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (cmd.emit_digit) begin
            digit_reg  <= u2da_pkg::ASCII_ZERO + {2'b00, bcd_reg[ptr_reg]};
            last_reg   <= (ptr_reg == '0);
            status_reg <= 1'b0;
        end else if (cmd.emit_error) begin
            digit_reg  <= 6'd0;
            last_reg   <= 1'b1;
            status_reg <= 1'b1;
        end
    end

    // Output register valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.emit_digit || cmd.emit_error) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // Status to controller
    assign sts.bits_done  = (bit_cnt_reg == '0);
    assign sts.fits       = ({{(u2da_pkg::FREE_WIDTH - DCW){1'b0}}, ndig_reg} <= free_reg);
    assign sts.last_digit = (ptr_reg == '0);
    assign sts.out_free   = !valid_reg || m_tready;

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, digit_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = status_reg;

    `UDA_ASSERT(a_no_overwrite, (cmd.emit_digit || cmd.emit_error) |-> sts.out_free, "pending result overwritten")
    `UDA_ASSERT(a_ndig_range, (ndig_reg >= DCW'(1)) && (ndig_reg <= DCW'(NUM_DIGITS)), "digit count out of range")
    `UDA_ASSERT(a_ptr_range, cmd.emit_digit |-> (ptr_reg < ndig_reg), "digit pointer beyond count")
    `UDA_ASSERT_NEXT(a_emit_valid, cmd.emit_digit || cmd.emit_error, m_tvalid, "emitted result not presented")

endmodule

// ===== rtl/unsigned_to_decimal_ascii_top.sv =====
// Top level of the unsigned binary to decimal ASCII converter
//
//  Group  Dir  tdata                             tlast        tuser
//  s_     in   [63:0] value, [79:64] free_bytes  -            -
//  m_     out  [5:0] digit_char, [7:6] zero      last         [0] status
//
// An item passes through an accept state, VALUE_WIDTH double-dabble steps (one bit each),
// a check state, then emits one result per digit (one for a buffer-too-small result).
// A new item is taken once the last result of the previous one is in the output register.
// A stalled m_tready holds the output register and pauses emission.
// aresetn is synchronous and clears the controller and the output valid flag.
module unsigned_to_decimal_ascii_top #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // [63:0] value, [79:64] free_bytes
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        m_tlast,
    output logic        m_tuser    // [0] status
);

    u2da_pkg::cmd_t    cmd;
    u2da_pkg::status_t sts;

    u2da_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    u2da_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_value (s_tdata[VALUE_WIDTH-1:0]),
        .in_free  (s_tdata[79:64]),
        .cmd      (cmd),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the unsigned binary to decimal ASCII converter
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          VALUE_WIDTH   = 64;
    localparam logic [63:0] VALUE_MASK    = (VALUE_WIDTH >= 64) ? '1
                                            : ((64'd1 << VALUE_WIDTH) - 64'd1);
    localparam int          MAX_DIGITS    = 20;
    localparam logic [5:0]  CHAR_ZERO     = u2da_pkg::ASCII_ZERO;
    localparam logic        STATUS_OK     = 1'b0;
    localparam logic        STATUS_SHORT  = 1'b1;
    localparam int          LONG_HOLD     = 300;
    localparam int          SETTLE_CYCLES = VALUE_WIDTH + 40;
    localparam int          CYCLE_LIMIT   = 1_000_000;
    localparam int          MAX_REPORTS   = 10;

    // One character (or one buffer-too-small notice) on the result stream
    typedef struct {
        logic [5:0] digit_char;
        logic       last;
        logic       status;
    } char_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;    // [63:0] value, [79:64] free_bytes
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [5:0] digit_char, [7:6] zero
    logic        m_tlast;
    logic        m_tuser;    // [0] status

    char_result_t pending_chars[$];
    char_result_t want;

    int mismatch_count;
    int chars_checked;
    int values_sent;
    int short_buffer_count;
    int cycle_count;

    // Sender burst/gap shaping
    int tx_max_gap;
    int tx_burst_left;

    // Receiver stall shaping
    int rx_stall_pct;
    int rx_run_left;
    bit rx_stalling;
    bit rx_hold_request;
    int rx_hold_left;

    unsigned_to_decimal_ascii_top #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // 2 ns clock
    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic logic [63:0] power_of_ten(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < n; i++) p = p * 64'd10;
        return p;
    endfunction

    function automatic int decimal_digit_count(input logic [63:0] value);
        logic [63:0] rest;
        int          n;
        rest = value & VALUE_MASK;
        n    = 0;
        do begin
            rest = rest / 64'd10;
            n++;
        end while (rest != 64'd0 && n < MAX_DIGITS);
        return n;
    endfunction

    // Queue the characters one value should produce
    function automatic void predict_decimal_text(input logic [63:0] value,
                                                 input logic [15:0] room);
        logic [63:0]  rest;
        logic [3:0]   digits [MAX_DIGITS];
        int           n;
        char_result_t r;
        rest = value & VALUE_MASK;
        n    = 0;
        do begin
            digits[n] = 4'(rest % 64'd10);
            rest      = rest / 64'd10;
            n++;
        end while (rest != 64'd0 && n < MAX_DIGITS);
        if (n > int'(room)) begin
            r.digit_char = 6'd0;
            r.last       = 1'b1;
            r.status     = STATUS_SHORT;
            pending_chars.push_back(r);
            short_buffer_count++;
        end else begin
            for (int k = 0; k < n; k++) begin
                r.digit_char = CHAR_ZERO + 6'(digits[n - 1 - k]);
                r.last       = (k == n - 1);
                r.status     = STATUS_OK;
                pending_chars.push_back(r);
            end
        end
    endfunction

    function automatic void note_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Offer one value; returns once the transfer has happened
    task automatic send_conversion(input logic [63:0] value, input logic [15:0] room);
        int gap;
        if (tx_burst_left == 0) begin
            if (tx_max_gap > 0) begin
                gap = $urandom_range(tx_max_gap, 1);
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
            tx_burst_left = $urandom_range(12, 1);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {room, value};
        do @(posedge aclk); while (!s_tready);
        predict_decimal_text(value, room);
        values_sent++;
        tx_burst_left--;
    endtask

    task automatic go_idle();
        @(negedge aclk);
        s_tvalid      <= 1'b0;
        tx_burst_left  = 0;
    endtask

    // Value spread over all magnitudes, with decade edges favored
    function automatic logic [63:0] random_value();
        int          pick;
        int          d;
        logic [63:0] v;
        pick = $urandom_range(9);
        d    = $urandom_range(19);
        case (pick)
            0: v = power_of_ten(d);
            1: v = power_of_ten(d) - 64'd1;
            2: v = power_of_ten(d) + 64'd1;
            3: v = 64'($urandom_range(9));
            default: v = {$urandom, $urandom} >> $urandom_range(63);
        endcase
        return v;
    endfunction

    // Room mostly around the digit count so both outcomes show up
    function automatic logic [15:0] random_room(input logic [63:0] value);
        int n;
        int pick;
        n    = decimal_digit_count(value);
        pick = $urandom_range(9);
        if (pick < 7)       return 16'(n + $urandom_range(3));
        else if (pick == 7) return 16'(n - 1);
        else if (pick == 8) return 16'($urandom_range(65535));
        else                return 16'd0;
    endfunction

    // Decade edges, full range and empty or tight buffers
    task automatic test_directed();
        tx_max_gap   = 3;
        rx_stall_pct = 20;
        send_conversion(64'd0, 16'd1);
        send_conversion(64'd0, 16'd0);
        send_conversion(64'd1, 16'd1);
        send_conversion(64'd9, 16'd1);
        send_conversion(64'd10, 16'd2);
        send_conversion(64'd10, 16'd1);
        send_conversion(64'd99, 16'd2);
        send_conversion(64'd100, 16'd3);
        send_conversion(64'd12345, 16'hFFFF);
        send_conversion(power_of_ten(19) - 64'd1, 16'd19);
        send_conversion(power_of_ten(19), 16'd20);
        send_conversion(power_of_ten(19), 16'd19);
        send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 16'd20);
        send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 16'd19);
        send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 16'd0);
        send_conversion(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
        send_conversion(64'd0, 16'hFFFF);
        send_conversion(64'h5555_5555_5555_5555, 16'h5555);
        send_conversion(64'hAAAA_AAAA_AAAA_AAAA, 16'hAAAA);
        send_conversion(64'h8000_0000_0000_0000, 16'd19);
        go_idle();
    endtask

    task automatic test_random(input int count, input int gap, input int stall_pct);
        logic [63:0] v;
        tx_max_gap   = gap;
        rx_stall_pct = stall_pct;
        repeat (count) begin
            v = random_value();
            send_conversion(v, random_room(v));
        end
        go_idle();
    endtask

    // Receiver holds off long enough for the input side to back up
    task automatic test_output_hold(input int count);
        logic [63:0] v;
        tx_max_gap   = 0;
        rx_stall_pct = 0;
        @(posedge aclk);
        rx_hold_request = 1'b1;
        repeat (count) begin
            v = random_value();
            send_conversion(v, random_room(v));
        end
        go_idle();
    endtask

    // Drive every input to a known level in reset, release reset, then run the tests
    initial begin
        aresetn         = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        m_tready        = 1'b0;
        tx_max_gap      = 0;
        tx_burst_left   = 0;
        rx_stall_pct    = 0;
        rx_run_left     = 0;
        rx_stalling     = 1'b0;
        rx_hold_request = 1'b0;
        rx_hold_left    = 0;
        mismatch_count  = 0;
        chars_checked   = 0;
        values_sent     = 0;
        short_buffer_count = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random(150, 6, 30);
        test_random(150, 2, 60);
        test_output_hold(40);
        test_random(20, 0, 0);

        while (pending_chars.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Converted %0d values (%0d buffer-too-small), checked %0d results.",
                 values_sent, short_buffer_count, chars_checked);
        $display("Covered 1 to 20 digit values, empty and full free counts, long output stall.");
        if (mismatch_count == 0 && pending_chars.size() == 0) begin
            $display("** unsigned_to_decimal_ascii_top: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     pending_chars.size());
            $display("** unsigned_to_decimal_ascii_top: FAILED **");
        end
        $finish;
    end

    // Receiver: runs of ready and stall, plus one requested long hold-off
    always @(negedge aclk) begin
        if (rx_hold_request) begin
            rx_hold_request = 1'b0;
            rx_hold_left    = LONG_HOLD;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_run_left == 0) begin
                rx_stalling = ($urandom_range(99) < rx_stall_pct);
                rx_run_left = $urandom_range(rx_stalling ? 8 : 12, 1);
            end
            rx_run_left--;
            m_tready <= !rx_stalling;
        end
    end

    // Compare every result transfer with the oldest expected character
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                note_mismatch($sformatf("unexpected result char=%0d last=%0b status=%0b",
                                        m_tdata[5:0], m_tlast, m_tuser));
            end else begin
                want = pending_chars.pop_front();
                chars_checked++;
                if (m_tdata !== {2'b00, want.digit_char} || m_tlast !== want.last ||
                    m_tuser !== want.status) begin
                    note_mismatch($sformatf(
                        "expected tdata=%0d last=%0b status=%0b, got tdata=%0d last=%0b status=%0b",
                        {2'b00, want.digit_char}, want.last, want.status,
                        m_tdata, m_tlast, m_tuser));
                end
            end
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                 pending_chars.size());
        $display("** unsigned_to_decimal_ascii_top: FAILED **");
        $finish;
    end

endmodule
